[sv/gwf_pkg.sv]
// gwf_pkg: shared types and codes of the grid wall follower
// used by gwf_nav and grid_wall_follower; depends on nothing
package gwf_pkg;

   localparam int GRID_MAX  = 128;
   localparam int COORD_W   = 7;
   localparam int SIZE_W    = 8;
   localparam int COUNT_W   = 14;
   localparam int MAP_DEPTH = GRID_MAX * GRID_MAX;
   localparam int MAP_AW    = 2 * COORD_W;

   typedef logic [1:0] dir_type;
   localparam dir_type DIR_E = 2'd0;
   localparam dir_type DIR_S = 2'd1;
   localparam dir_type DIR_W = 2'd2;
   localparam dir_type DIR_N = 2'd3;

   typedef logic [1:0] op_type;
   localparam op_type OP_WRITE = 2'd0;
   localparam op_type OP_START = 2'd1;
   localparam op_type OP_STEP  = 2'd2;

   typedef logic [2:0] status_type;
   localparam status_type ST_ACK     = 3'd0;
   localparam status_type ST_MOVED   = 3'd1;
   localparam status_type ST_ARRIVED = 3'd2;
   localparam status_type ST_OUT     = 3'd3;
   localparam status_type ST_DONE    = 3'd4;

   typedef logic [2:0] csr_idx_type;
   localparam csr_idx_type CSR_GRID_SIZE  = 3'd0;
   localparam csr_idx_type CSR_START_ROW  = 3'd1;
   localparam csr_idx_type CSR_START_COL  = 3'd2;
   localparam csr_idx_type CSR_END_ROW    = 3'd3;
   localparam csr_idx_type CSR_END_COL    = 3'd4;
   localparam csr_idx_type CSR_STEP_LIMIT = 3'd5;

   // decision of the navigation logic for one start or step
   typedef struct packed {
      logic    found;
      dir_type dir;
      dir_type facing_turn;
      logic    lws_new;
   } nav_res_type;

endpackage

[sv/gwf_nav.sv]
// gwf_nav: picks the heading from the four neighbour open bits
// depends on gwf_pkg
module gwf_nav import gwf_pkg::*; (
   input  logic        is_start,
   input  logic [3:0]  open_dirs,
   input  dir_type     facing,
   input  logic        left_wall_seen,
   output nav_res_type res
);

   always_comb begin
      logic    seen;
      dir_type ft;
      dir_type d;
      res  = '0;
      seen = 1'b0;
      ft   = facing;
      d    = DIR_E;
      if (is_start) begin
         // first open neighbour clockwise that comes after a wall or the edge
         for (int i = 0; i < 4; i++) begin
            if (!open_dirs[i]) begin
               seen = 1'b1;
            end
            if (seen && open_dirs[i] && !res.found) begin
               res.found = 1'b1;
               res.dir   = dir_type'(i);
            end
         end
      end else begin
         if (left_wall_seen && open_dirs[facing + 2'd3]) begin
            ft = facing + 2'd3;
         end
         // forward, right, back, left
         for (int i = 0; i < 4; i++) begin
            d = ft + dir_type'(i);
            if (open_dirs[d] && !res.found) begin
               res.found = 1'b1;
               res.dir   = d;
            end
         end
         res.facing_turn = ft;
         res.lws_new     = !open_dirs[ft + 2'd3];
      end
   end

endmodule

[sv/grid_wall_follower.sv]
// grid_wall_follower: top level of the left-hand wall-following walker
// depends on gwf_pkg and gwf_nav
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one response, shown for one cycle with rsp_strobe high; the
// receiver cannot stall it. Map writes, unused op codes, steps after the walk
// ended and steps at the move limit are answered at once: the response shows
// in the next cycle and busy stays low, so such requests can come every
// cycle. Start and step requests read the four neighbours of the walker from
// the single-port 16384 x 1 map memory, one per cycle, and then decide; busy
// stays high while reading and deciding, the response follows the decision,
// and a new request can be taken at the edge that ends the response cycle.
// The map is not cleared at reset; a cell that was never written reads as
// garbage. csr_ready is always high; write registers only while no request
// is outstanding.
module grid_wall_follower import gwf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  op_type               req_op,
   input  logic [COORD_W-1:0]   req_cell_row,
   input  logic [COORD_W-1:0]   req_cell_col,
   input  logic                 req_cell_open,
   // response channel
   output logic                 rsp_strobe,
   output status_type           rsp_status,
   output dir_type              rsp_heading,
   output logic [COORD_W-1:0]   rsp_pos_row,
   output logic [COORD_W-1:0]   rsp_pos_col,
   output logic [COUNT_W-1:0]   rsp_moves_made,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  csr_idx_type          csr_index,
   input  logic [COUNT_W-1:0]   csr_wdata
);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL} state_type;

   state_type            state_ff;
   logic                 is_start_ff;
   dir_type              rd_ff;

   // configuration registers
   logic [SIZE_W-1:0]    grid_size_ff;
   logic [COORD_W-1:0]   start_row_ff, start_col_ff, end_row_ff, end_col_ff;
   logic [COUNT_W-1:0]   step_limit_ff;

   // walker state
   logic [COORD_W-1:0]   row_ff, col_ff;
   dir_type              facing_ff;
   logic                 lws_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 done_ff;

   // neighbour collection
   logic                 inb_ff;
   logic [2:0]           nb_ff;
   logic [3:0]           open_dirs;

   // map memory
   logic                 map_mem [0:MAP_DEPTH-1];
   logic                 rdata_ff;
   logic                 mem_we, mem_re;
   logic [MAP_AW-1:0]    mem_addr;

   logic                 accept;
   logic [SIZE_W-1:0]    eff_size;
   logic [SIZE_W-1:0]    nb_row, nb_col;
   logic                 nb_neg, nb_inb;

   nav_res_type          nav;
   logic [COORD_W-1:0]   mv_row, mv_col;
   logic [COUNT_W-1:0]   mv_count;
   dir_type              start_facing;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // grid side saturates at the storage size
   assign eff_size = (grid_size_ff > SIZE_W'(GRID_MAX)) ? SIZE_W'(GRID_MAX) : grid_size_ff;

   // neighbour coordinates for the direction being read
   always_comb begin
      nb_row = {1'b0, row_ff};
      nb_col = {1'b0, col_ff};
      nb_neg = 1'b0;
      unique case (rd_ff)
         DIR_E: nb_col = {1'b0, col_ff} + SIZE_W'(1);
         DIR_S: nb_row = {1'b0, row_ff} + SIZE_W'(1);
         DIR_W: begin
            nb_neg = (col_ff == '0);
            nb_col = {1'b0, col_ff} - SIZE_W'(1);
         end
         DIR_N: begin
            nb_neg = (row_ff == '0);
            nb_row = {1'b0, row_ff} - SIZE_W'(1);
         end
         default: ;
      endcase
      nb_inb = !nb_neg && (nb_row < eff_size) && (nb_col < eff_size);
   end

   // single port: writes only at request time, reads only while collecting
   assign mem_we   = accept && (req_op == OP_WRITE);
   assign mem_re   = (state_ff == S_READ);
   assign mem_addr = mem_we ? {req_cell_row, req_cell_col}
                            : {nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_addr] <= req_cell_open;
      end else if (mem_re) begin
         rdata_ff <= map_mem[mem_addr];
      end
   end

   // last neighbour (north) comes straight from the read register
   assign open_dirs = {rdata_ff & inb_ff, nb_ff};

   gwf_nav u_nav (
      .is_start       (is_start_ff),
      .open_dirs      (open_dirs),
      .facing         (facing_ff),
      .left_wall_seen (lws_ff),
      .res            (nav)
   );

   assign start_facing = nav.found ? nav.dir : DIR_E;

   // one move in the chosen direction
   always_comb begin
      mv_row = row_ff;
      mv_col = col_ff;
      unique case (nav.dir)
         DIR_E: mv_col = col_ff + COORD_W'(1);
         DIR_S: mv_row = row_ff + COORD_W'(1);
         DIR_W: mv_col = col_ff - COORD_W'(1);
         DIR_N: mv_row = row_ff - COORD_W'(1);
         default: ;
      endcase
      mv_count = count_ff + COUNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         is_start_ff   <= 1'b0;
         rd_ff         <= DIR_E;
         grid_size_ff  <= SIZE_W'(GRID_MAX);
         start_row_ff  <= '0;
         start_col_ff  <= '0;
         end_row_ff    <= '0;
         end_col_ff    <= '0;
         step_limit_ff <= COUNT_W'(10000);
         row_ff        <= '0;
         col_ff        <= '0;
         facing_ff     <= DIR_E;
         lws_ff        <= 1'b0;
         count_ff      <= '0;
         done_ff       <= 1'b1;
         rsp_strobe    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GRID_SIZE:  grid_size_ff  <= csr_wdata[SIZE_W-1:0];
               CSR_START_ROW:  start_row_ff  <= csr_wdata[COORD_W-1:0];
               CSR_START_COL:  start_col_ff  <= csr_wdata[COORD_W-1:0];
               CSR_END_ROW:    end_row_ff    <= csr_wdata[COORD_W-1:0];
               CSR_END_COL:    end_col_ff    <= csr_wdata[COORD_W-1:0];
               CSR_STEP_LIMIT: step_limit_ff <= csr_wdata;
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rd_ff <= DIR_E;
                  priority if (req_op == OP_START) begin
                     // fresh walk, then look around the start cell
                     row_ff      <= start_row_ff;
                     col_ff      <= start_col_ff;
                     facing_ff   <= DIR_E;
                     lws_ff      <= 1'b0;
                     count_ff    <= '0;
                     done_ff     <= 1'b0;
                     is_start_ff <= 1'b1;
                     state_ff    <= S_READ;
                     rsp_strobe  <= 1'b0;
                  end else if (req_op == OP_STEP && done_ff) begin
                     rsp_strobe     <= 1'b1;
                     rsp_status     <= ST_DONE;
                     rsp_heading    <= facing_ff;
                     rsp_pos_row    <= row_ff;
                     rsp_pos_col    <= col_ff;
                     rsp_moves_made <= count_ff;
                  end else if (req_op == OP_STEP && count_ff >= step_limit_ff) begin
                     // limit reached before moving
                     done_ff        <= 1'b1;
                     rsp_strobe     <= 1'b1;
                     rsp_status     <= ST_OUT;
                     rsp_heading    <= facing_ff;
                     rsp_pos_row    <= row_ff;
                     rsp_pos_col    <= col_ff;
                     rsp_moves_made <= count_ff;
                  end else if (req_op == OP_STEP) begin
                     is_start_ff <= 1'b0;
                     state_ff    <= S_READ;
                     rsp_strobe  <= 1'b0;
                  end else begin
                     // map write or unused code
                     rsp_strobe     <= 1'b1;
                     rsp_status     <= ST_ACK;
                     rsp_heading    <= facing_ff;
                     rsp_pos_row    <= row_ff;
                     rsp_pos_col    <= col_ff;
                     rsp_moves_made <= count_ff;
                  end
               end else begin
                  rsp_strobe <= 1'b0;
               end
            end

            S_READ: begin
               // read one neighbour, shift in the one read before it
               rsp_strobe <= 1'b0;
               inb_ff     <= nb_inb;
               rd_ff      <= rd_ff + 2'd1;
               if (rd_ff != DIR_E) begin
                  nb_ff <= {rdata_ff & inb_ff, nb_ff[2:1]};
               end
               if (rd_ff == DIR_N) begin
                  state_ff <= S_EVAL;
               end
            end

            S_EVAL: begin
               state_ff   <= S_IDLE;
               rsp_strobe <= 1'b1;
               if (is_start_ff) begin
                  facing_ff      <= start_facing;
                  rsp_status     <= ST_ACK;
                  rsp_heading    <= start_facing;
                  rsp_pos_row    <= row_ff;
                  rsp_pos_col    <= col_ff;
                  rsp_moves_made <= count_ff;
               end else if (!nav.found) begin
                  // boxed in: keep any left turn, end the walk
                  facing_ff      <= nav.facing_turn;
                  lws_ff         <= 1'b0;
                  done_ff        <= 1'b1;
                  rsp_status     <= ST_OUT;
                  rsp_heading    <= nav.facing_turn;
                  rsp_pos_row    <= row_ff;
                  rsp_pos_col    <= col_ff;
                  rsp_moves_made <= count_ff;
               end else begin
                  facing_ff      <= nav.dir;
                  lws_ff         <= nav.lws_new;
                  row_ff         <= mv_row;
                  col_ff         <= mv_col;
                  count_ff       <= mv_count;
                  rsp_heading    <= nav.dir;
                  rsp_pos_row    <= mv_row;
                  rsp_pos_col    <= mv_col;
                  rsp_moves_made <= mv_count;
                  // arrival wins over the limit on the same move
                  priority if (mv_row == end_row_ff && mv_col == end_col_ff) begin
                     done_ff    <= 1'b1;
                     rsp_status <= ST_ARRIVED;
                  end else if (mv_count >= step_limit_ff) begin
                     done_ff    <= 1'b1;
                     rsp_status <= ST_OUT;
                  end else begin
                     rsp_status <= ST_MOVED;
                  end
               end
            end

            default: begin
               state_ff   <= S_IDLE;
               rsp_strobe <= 1'b0;
            end
         endcase
      end
   end

endmodule

[dv/grid_wall_follower_tb.sv]
// grid_wall_follower_tb: self-checking bench for the left-hand wall-following walker
// drives map writes, walk starts and steps; a walk tracker class predicts every response
// depends on gwf_pkg and the grid_wall_follower rtl
module grid_wall_follower_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gwf_pkg::*;

   // op code the block leaves unused: acknowledged, nothing else
   localparam op_type OP_SPARE = 2'd3;
   // settle time after the last response before a register write or the end
   localparam int DRAIN_CYCLES = 8;
   // requests to send in total before the run winds down
   localparam int ITEM_TARGET = 905;

   typedef struct {
      status_type         status;
      dir_type            heading;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COUNT_W-1:0] moves;
   } walk_report_type;

   // mirrors the walker: map, registers and walk state, plus the reports still owed
   class walk_tracker;
      bit                 map_open [MAP_DEPTH];
      logic [SIZE_W-1:0]  grid_size;
      logic [COORD_W-1:0] start_row, start_col, end_row, end_col;
      logic [COUNT_W-1:0] step_limit;
      logic [COORD_W-1:0] row, col;
      dir_type            face;
      bit                 left_wall;
      logic [COUNT_W-1:0] moves;
      bit                 finished;
      walk_report_type    reports [$];
      int                 errors;

      function new();
         grid_size  = 8'd128;
         start_row  = '0;
         start_col  = '0;
         end_row    = '0;
         end_col    = '0;
         step_limit = 14'd10000;
         row        = '0;
         col        = '0;
         face       = DIR_E;
         left_wall  = 1'b0;
         moves      = '0;
         finished   = 1'b1;
         errors     = 0;
      endfunction

      // side of the grid in use, saturated at the map size
      function int side();
         return (grid_size > GRID_MAX) ? GRID_MAX : int'(grid_size);
      endfunction

      // neighbour of the walker in direction d lies inside the grid and is open
      function bit open_dir(dir_type d);
         int r, c;
         r = int'(row);
         c = int'(col);
         case (d)
            DIR_E:   c++;
            DIR_S:   r++;
            DIR_W:   c--;
            default: r--;
         endcase
         if (r < 0 || c < 0 || r >= side() || c >= side())
            return 1'b0;
         return map_open[r * GRID_MAX + c];
      endfunction

      function void set_reg(csr_idx_type idx, logic [COUNT_W-1:0] val);
         case (idx)
            CSR_GRID_SIZE:  grid_size  = val[SIZE_W-1:0];
            CSR_START_ROW:  start_row  = val[COORD_W-1:0];
            CSR_START_COL:  start_col  = val[COORD_W-1:0];
            CSR_END_ROW:    end_row    = val[COORD_W-1:0];
            CSR_END_COL:    end_col    = val[COORD_W-1:0];
            CSR_STEP_LIMIT: step_limit = val;
            default: ;
         endcase
      endfunction

      // apply one accepted request and queue the response it owes
      function void note_request(op_type op, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                 logic is_open);
         walk_report_type rep;
         dir_type         d, lft;
         bit              seen, found;
         int              i;
         rep.status = ST_ACK;
         case (op)
            OP_WRITE: map_open[int'(r) * GRID_MAX + int'(c)] = is_open;
            OP_START: begin
               row       = start_row;
               col       = start_col;
               face      = DIR_E;
               left_wall = 1'b0;
               moves     = '0;
               finished  = 1'b0;
               seen      = 1'b0;
               // clockwise from east: first open cell after a wall or the edge
               for (i = 0; i < 4; i++) begin
                  d = dir_type'(i);
                  if (!open_dir(d))
                     seen = 1'b1;
                  else if (seen) begin
                     face = d;
                     break;
                  end
               end
            end
            OP_STEP: begin
               if (finished)
                  rep.status = ST_DONE;
               else if (moves >= step_limit) begin
                  finished   = 1'b1;
                  rep.status = ST_OUT;
               end else begin
                  lft = face + 2'd3;
                  if (left_wall && open_dir(lft))
                     face = lft;
                  left_wall = 1'b0;
                  found     = 1'b0;
                  // forward, right, back, left
                  for (i = 0; i < 4 && !found; i++) begin
                     d     = face + dir_type'(i);
                     found = open_dir(d);
                  end
                  if (!found) begin
                     finished   = 1'b1;
                     rep.status = ST_OUT;
                  end else begin
                     lft       = face + 2'd3;
                     left_wall = !open_dir(lft);
                     face      = d;
                     case (d)
                        DIR_E:   col++;
                        DIR_S:   row++;
                        DIR_W:   col--;
                        default: row--;
                     endcase
                     moves++;
                     if (row == end_row && col == end_col) begin
                        finished   = 1'b1;
                        rep.status = ST_ARRIVED;
                     end else if (moves >= step_limit) begin
                        finished   = 1'b1;
                        rep.status = ST_OUT;
                     end else
                        rep.status = ST_MOVED;
                  end
               end
            end
            default: ;
         endcase
         rep.heading = face;
         rep.row     = row;
         rep.col     = col;
         rep.moves   = moves;
         reports.push_back(rep);
      endfunction

      function void check_result(walk_report_type got);
         walk_report_type want;
         if (reports.size() == 0) begin
            $error("response with no request outstanding: status %0d at (%0d,%0d)",
                   got.status, got.row, got.col);
            errors++;
            return;
         end
         want = reports.pop_front();
         if (got.status !== want.status) begin
            $error("rsp_status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.heading !== want.heading) begin
            $error("rsp_heading: expected %0d, got %0d", want.heading, got.heading);
            errors++;
         end
         if (got.row !== want.row) begin
            $error("rsp_pos_row: expected %0d, got %0d", want.row, got.row);
            errors++;
         end
         if (got.col !== want.col) begin
            $error("rsp_pos_col: expected %0d, got %0d", want.col, got.col);
            errors++;
         end
         if (got.moves !== want.moves) begin
            $error("rsp_moves_made: expected %0d, got %0d", want.moves, got.moves);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   op_type             req_op;
   logic [COORD_W-1:0] req_cell_row;
   logic [COORD_W-1:0] req_cell_col;
   logic               req_cell_open;
   logic               rsp_strobe;
   status_type         rsp_status;
   dir_type            rsp_heading;
   logic [COORD_W-1:0] rsp_pos_row;
   logic [COORD_W-1:0] rsp_pos_col;
   logic [COUNT_W-1:0] rsp_moves_made;
   logic               csr_valid;
   logic               csr_ready;
   csr_idx_type        csr_index;
   logic [COUNT_W-1:0] csr_wdata;

   walk_tracker tracker = new();
   int          sent;        // requests accepted so far
   int          idle_pct;    // chance of a sender gap ahead of each request
   // map region written in the current phase; the walker never leaves it
   int          rect_r0, rect_c0, rect_r1, rect_c1;

   grid_wall_follower uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // responses cannot be held off, so every strobe is checked at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_result(walk_report_type'{rsp_status, rsp_heading, rsp_pos_row,
                                                rsp_pos_col, rsp_moves_made});
   end

   function automatic bit in_rect(int r, int c);
      return r >= rect_r0 && r <= rect_r1 && c >= rect_c0 && c <= rect_c1;
   endfunction

   // every in-grid neighbour of the cell lies in the region, so a walker
   // standing here only reads cells written in this phase
   function automatic bit safe_cell(int r, int c);
      int n, k, nr, nc;
      n = tracker.side();
      for (k = 0; k < 4; k++) begin
         nr = r + ((k == 1) ? 1 : (k == 3) ? -1 : 0);
         nc = c + ((k == 0) ? 1 : (k == 2) ? -1 : 0);
         if (nr >= 0 && nc >= 0 && nr < n && nc < n && !in_rect(nr, nc))
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // one request; start stays high until the block takes it, a random gap may come first
   task automatic send_request(op_type op, int r, int c, bit is_open);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      @(negedge clock);
      start  = 1'b1;
      req_op = op;
      if (op == OP_WRITE) begin
         req_cell_row  = COORD_W'(r);
         req_cell_col  = COORD_W'(c);
         req_cell_open = is_open;
      end else begin
         // cell fields mean nothing here, so they carry noise
         req_cell_row  = COORD_W'($urandom_range(0, 127));
         req_cell_col  = COORD_W'($urandom_range(0, 127));
         req_cell_open = 1'($urandom_range(0, 1));
      end
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_request(op, req_cell_row, req_cell_col, req_cell_open);
      sent++;
   endtask

   // wait for every owed response, then let the block settle
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (tracker.reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, int val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = COUNT_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_reg(idx, csr_wdata);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one random phase: grid size, a walled-in region of the map, then a few walks
   task automatic run_phase(int phase);
      int size_val, n, h, w, pick, r, c, sr, sc, er, ec, lim, tries, open_pct;
      drain();
      case (phase % 4)
         1:       idle_pct = 51;
         3:       idle_pct = 9;
         default: idle_pct = 0;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0)
         size_val = 128;
      else if (pick == 1)
         size_val = $urandom_range(129, 255);   // saturates to the map size
      else if (pick == 2)
         size_val = $urandom_range(13, 127);
      else
         size_val = $urandom_range(1, 10);
      write_csr(CSR_GRID_SIZE, size_val);
      n = tracker.side();

      // small grids are written whole; large ones get a small region, often in a corner
      if (n <= 12) begin
         rect_r0 = 0;
         rect_c0 = 0;
         rect_r1 = n - 1;
         rect_c1 = n - 1;
      end else begin
         h    = $urandom_range(3, 10);
         w    = $urandom_range(3, 10);
         pick = $urandom_range(0, 2);
         rect_r0 = (pick == 0) ? 0 : (pick == 1) ? n - h : $urandom_range(0, n - h);
         pick = $urandom_range(0, 2);
         rect_c0 = (pick == 0) ? 0 : (pick == 1) ? n - w : $urandom_range(0, n - w);
         rect_r1 = rect_r0 + h - 1;
         rect_c1 = rect_c0 + w - 1;
      end
      // cells on the region border that face the rest of the grid stay walls
      open_pct = $urandom_range(45, 85);
      for (r = rect_r0; r <= rect_r1; r++)
         for (c = rect_c0; c <= rect_c1; c++)
            send_request(OP_WRITE, r, c, safe_cell(r, c) && $urandom_range(99) < open_pct);

      repeat ($urandom_range(1, 3)) begin
         drain();
         // start cell: mostly open floor, sometimes a wall, sometimes off the grid
         sr = -1;
         sc = -1;
         for (tries = 0; tries < 40 && sr < 0; tries++) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               r = $urandom_range(rect_r0, rect_r1);
               c = $urandom_range(rect_c0, rect_c1);
               if (safe_cell(r, c) && (pick >= 6 || tracker.map_open[r * GRID_MAX + c])) begin
                  sr = r;
                  sc = c;
               end
            end else begin
               r = $urandom_range(0, 1) ? ((n < 127) ? n + $urandom_range(0, 1) : 127)
                                        : $urandom_range(0, 127);
               c = $urandom_range(0, 127);
               if ((r >= n || c >= n) && safe_cell(r, c)) begin
                  sr = r;
                  sc = c;
               end
            end
         end
         if (sr < 0) begin
            sr = rect_r0 + ((rect_r1 - rect_r0 >= 2) ? 1 : 0);
            sc = rect_c0 + ((rect_c1 - rect_c0 >= 2) ? 1 : 0);
         end
         // goal mostly inside the region, otherwise anywhere, off the grid included
         if ($urandom_range(0, 3) != 0) begin
            er = $urandom_range(rect_r0, rect_r1);
            ec = $urandom_range(rect_c0, rect_c1);
         end else begin
            er = $urandom_range(0, 127);
            ec = $urandom_range(0, 127);
         end
         pick = $urandom_range(0, 9);
         lim  = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 16383 : $urandom_range(2, 40);
         write_csr(CSR_START_ROW, sr);
         write_csr(CSR_START_COL, sc);
         write_csr(CSR_END_ROW, er);
         write_csr(CSR_END_COL, ec);
         write_csr(CSR_STEP_LIMIT, lim);

         send_request(OP_START, 0, 0, 1'b0);
         repeat ($urandom_range(4, 40)) begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
               send_request(OP_STEP, 0, 0, 1'b0);
            else if (pick < 91) begin
               // cells outside the region are never read, so anything goes
               do begin
                  r = $urandom_range(0, 127);
                  c = $urandom_range(0, 127);
               end while (in_rect(r, c));
               send_request(OP_WRITE, r, c, 1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
               // reshape the maze under the walker
               r = $urandom_range(rect_r0, rect_r1);
               c = $urandom_range(rect_c0, rect_c1);
               send_request(OP_WRITE, r, c, safe_cell(r, c) && $urandom_range(0, 1));
            end else if (pick < 97)
               send_request(OP_SPARE, 0, 0, 1'b0);
            else if (pick < 98)
               send_request(OP_START, 0, 0, 1'b0);
            else begin
               // pull the move budget down to, or just below, what the walker has already used
               drain();
               lim = int'(tracker.moves) - $urandom_range(0, 1);
               write_csr(CSR_STEP_LIMIT, (lim < 0) ? 0 : lim);
            end
         end
      end
   endtask

   initial begin
      int phase;
      int r, c;
      reset         = 1'b1;
      start         = 1'b0;
      req_op        = OP_WRITE;
      req_cell_row  = '0;
      req_cell_col  = '0;
      req_cell_open = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CSR_GRID_SIZE;
      csr_wdata     = '0;
      idle_pct      = 0;
      sent          = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no walk yet: a step is refused, the spare code only acknowledged
      send_request(OP_STEP, 0, 0, 1'b0);
      send_request(OP_SPARE, 0, 0, 1'b0);
      // writes at both far corners of the map
      send_request(OP_WRITE, 127, 127, 1'b1);
      send_request(OP_WRITE, 0, 0, 1'b0);

      // one-cell grid, goal off the grid, zero move budget
      drain();
      write_csr(CSR_GRID_SIZE, 1);
      write_csr(CSR_END_ROW, 1);
      write_csr(CSR_END_COL, 1);
      write_csr(CSR_STEP_LIMIT, 0);
      send_request(OP_WRITE, 0, 0, 1'b1);
      send_request(OP_START, 0, 0, 1'b0);   // no neighbour qualifies, stays east
      send_request(OP_STEP, 0, 0, 1'b0);    // budget already spent
      drain();
      write_csr(CSR_STEP_LIMIT, 5);
      send_request(OP_START, 0, 0, 1'b0);
      send_request(OP_STEP, 0, 0, 1'b0);    // boxed in: out of energy without a move
      send_request(OP_STEP, 0, 0, 1'b0);    // walk already over

      // 3x3 ring of floor around a wall
      drain();
      write_csr(CSR_GRID_SIZE, 3);
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            send_request(OP_WRITE, r, c, !(r == 1 && c == 1));
      // start just below the grid, goal one move away on the last allowed move
      drain();
      write_csr(CSR_START_ROW, 3);
      write_csr(CSR_START_COL, 0);
      write_csr(CSR_END_ROW, 2);
      write_csr(CSR_END_COL, 0);
      write_csr(CSR_STEP_LIMIT, 1);
      send_request(OP_START, 0, 0, 1'b0);   // only north is open, faces it
      send_request(OP_STEP, 0, 0, 1'b0);    // arrival wins over the spent budget
      // start on the wall in the middle, all neighbours open
      drain();
      write_csr(CSR_START_ROW, 1);
      write_csr(CSR_START_COL, 1);
      write_csr(CSR_END_ROW, 0);
      write_csr(CSR_END_COL, 0);
      write_csr(CSR_STEP_LIMIT, 16383);
      send_request(OP_START, 0, 0, 1'b0);
      repeat (4) send_request(OP_STEP, 0, 0, 1'b0);

      for (phase = 0; sent < ITEM_TARGET; phase++)
         run_phase(phase);

      drain();
      if (tracker.errors == 0 && tracker.reports.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[grid_wall_follower.f]
sv/gwf_pkg.sv
sv/gwf_nav.sv
sv/grid_wall_follower.sv
dv/grid_wall_follower_tb.sv
